// ----- hw/rtl/ttus_pkg.sv -----
// types, codes and helpers shared by the tiled texture upload swizzle core
// no dependencies
package ttus_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 11;
    localparam int unsigned INDEX_W     = 20;
    localparam int unsigned TEXEL_W     = 32;
    localparam int unsigned LOG2_W      = 4;
    localparam int unsigned COPY_W      = 11;
    localparam int unsigned FMT_W       = 2;
    localparam int unsigned MIN_LOG2    = 3;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_LOG2   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT_LOG2  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COPY_WIDTH   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_COPY_HEIGHT  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_FORMAT = 3'd4;

    // pixel formats
    localparam logic [FMT_W-1:0] FMT_RGBA8_RGBA = 2'd0;
    localparam logic [FMT_W-1:0] FMT_RGBA8_RGB  = 2'd1;
    localparam logic [FMT_W-1:0] FMT_16BIT      = 2'd2;
    localparam logic [FMT_W-1:0] FMT_8BIT       = 2'd3;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic [LOG2_W-1:0] width_log2;
        logic [LOG2_W-1:0] height_log2;
        logic [COPY_W-1:0] copy_width;
        logic [COPY_W-1:0] copy_height;
        logic [FMT_W-1:0]  pixel_format;
    } ttus_cfg_t;

    // clamp a side log2 into [3, max_log2]
    function automatic logic [LOG2_W-1:0] side_log2(input logic [LOG2_W-1:0] v,
                                                    input logic [LOG2_W-1:0] max_log2);
        logic [LOG2_W-1:0] r;
        if (v < LOG2_W'(MIN_LOG2)) begin
            r = LOG2_W'(MIN_LOG2);
        end else if (v > max_log2) begin
            r = max_log2;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/ttus_cfg.sv -----
// configuration register file of the swizzle core
// depends on ttus_pkg
module ttus_cfg (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ttus_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ttus_pkg::CFG_DATA_W-1:0]      cfg_data,
    output ttus_pkg::ttus_cfg_t                  cfg
);
    import ttus_pkg::*;

    ttus_cfg_t cfg_reg;
    ttus_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_WIDTH_LOG2:   cfg_next.width_log2   = cfg_data[LOG2_W-1:0];
                REG_HEIGHT_LOG2:  cfg_next.height_log2  = cfg_data[LOG2_W-1:0];
                REG_COPY_WIDTH:   cfg_next.copy_width   = cfg_data[COPY_W-1:0];
                REG_COPY_HEIGHT:  cfg_next.copy_height  = cfg_data[COPY_W-1:0];
                REG_PIXEL_FORMAT: cfg_next.pixel_format = cfg_data[FMT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.width_log2   <= LOG2_W'(MIN_LOG2);
            cfg_reg.height_log2  <= LOG2_W'(MIN_LOG2);
            cfg_reg.copy_width   <= '0;
            cfg_reg.copy_height  <= '0;
            cfg_reg.pixel_format <= FMT_RGBA8_RGBA;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- hw/rtl/ttus_pos.sv -----
// raster position counters: column and row of the item being accepted
// depends on ttus_pkg
module ttus_pos #(
    parameter int unsigned MAX_SIDE_LOG2 = 10
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  ttus_pkg::ttus_cfg_t       cfg,
    input  logic                      advance,
    input  logic                      frame_start,
    output logic [MAX_SIDE_LOG2-1:0]  pos_x,
    output logic [MAX_SIDE_LOG2-1:0]  pos_y
);
    import ttus_pkg::*;

    localparam int unsigned SW = MAX_SIDE_LOG2;

    logic [SW-1:0]     column_reg, column_next;
    logic [SW-1:0]     row_reg, row_next;
    logic [LOG2_W-1:0] wl, hl;
    logic [SW-1:0]     mask_w, mask_h;

    assign wl     = side_log2(cfg.width_log2, LOG2_W'(MAX_SIDE_LOG2));
    assign hl     = side_log2(cfg.height_log2, LOG2_W'(MAX_SIDE_LOG2));
    assign mask_w = ~({SW{1'b1}} << wl);
    assign mask_h = ~({SW{1'b1}} << hl);

    // counters are masked in case the side shrank mid frame
    assign pos_x = frame_start ? '0 : (column_reg & mask_w);
    assign pos_y = frame_start ? '0 : (row_reg & mask_h);

    always_comb begin
        column_next = column_reg;
        row_next    = row_reg;
        if (advance) begin
            if (pos_x == mask_w) begin
                column_next = '0;
                row_next    = (pos_y == mask_h) ? '0 : pos_y + SW'(1);
            end else begin
                column_next = pos_x + SW'(1);
                row_next    = pos_y;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg <= '0;
            row_reg    <= '0;
        end else begin
            column_reg <= column_next;
            row_reg    <= row_next;
        end
    end

endmodule

// ----- hw/rtl/ttus_pack.sv -----
// tiled address, texel packing and last flag for one registered position
// depends on ttus_pkg
module ttus_pack #(
    parameter int unsigned MAX_SIDE_LOG2 = 10
) (
    input  ttus_pkg::ttus_cfg_t              cfg,
    input  logic [MAX_SIDE_LOG2-1:0]         pos_x,
    input  logic [MAX_SIDE_LOG2-1:0]         pos_y,
    input  logic [31:0]                      src_bytes,
    output logic [ttus_pkg::INDEX_W-1:0]     element_index,
    output logic [ttus_pkg::TEXEL_W-1:0]     texel_value,
    output logic                             frame_last
);
    import ttus_pkg::*;

    localparam int unsigned SW    = MAX_SIDE_LOG2;
    localparam int unsigned IW    = (2 * SW > INDEX_W) ? 2 * SW : INDEX_W;
    localparam int unsigned CMP_W = (SW > COPY_W) ? SW : COPY_W;

    logic [LOG2_W-1:0] wl, hl;
    logic [SW-1:0]     mask_w, mask_h;
    logic [SW-1:0]     fy;
    logic [5:0]        morton;
    logic [IW-1:0]     idx_wide;
    logic              in_rect;

    assign wl     = side_log2(cfg.width_log2, LOG2_W'(MAX_SIDE_LOG2));
    assign hl     = side_log2(cfg.height_log2, LOG2_W'(MAX_SIDE_LOG2));
    assign mask_w = ~({SW{1'b1}} << wl);
    assign mask_h = ~({SW{1'b1}} << hl);

    // vertical flip; y never exceeds the mask so no wrap
    assign fy = mask_h - pos_y;

    assign morton = {fy[2], pos_x[2], fy[1], pos_x[1], fy[0], pos_x[0]};

    // tile row * tiles per row * 64 is a shift by wl+3 since the width is a power of two
    assign idx_wide = (IW'(fy >> 3) << (wl + LOG2_W'(3)))
                    | (IW'(pos_x >> 3) << 6)
                    | IW'(morton);
    assign element_index = idx_wide[INDEX_W-1:0];

    assign in_rect = (CMP_W'(pos_x) < CMP_W'(cfg.copy_width))
                  && (CMP_W'(pos_y) < CMP_W'(cfg.copy_height));

    always_comb begin
        texel_value = '0;
        if (in_rect) begin
            case (cfg.pixel_format)
                FMT_RGBA8_RGBA: texel_value = src_bytes;
                FMT_RGBA8_RGB:  texel_value = {ALPHA_OPAQUE, src_bytes[23:0]};
                FMT_16BIT:      texel_value = {16'h0000, src_bytes[15:0]};
                FMT_8BIT:       texel_value = {24'h000000, src_bytes[7:0]};
                default:        texel_value = '0;
            endcase
        end
    end

    assign frame_last = (pos_x == mask_w) && (pos_y == mask_h);

endmodule

// ----- hw/rtl/tiled_texture_upload_swizzle_core.sv -----
// top level of the tiled texture upload swizzle core
// depends on ttus_pkg, ttus_cfg, ttus_pos, ttus_pack
//
//   channel   direction  handshake              payload
//   s_        in         s_tvalid / s_tready    tdata: byte0..byte3, tuser: frame_start
//   m_        out        m_tvalid / m_tready    tdata: element_index, texel_value; tlast
//   cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one item per cycle sustained while m_tready stays high; each accepted item passes the
// position register, then the result register, where m_tvalid rises and it can be taken
// aresetn clears counters and pipeline valids and sets the config registers to their reset values
// a stalled result holds in the output register while one more item waits in the
// position register; s_tready drops only when both are full and m_tready is low
module tiled_texture_upload_swizzle_core #(
    parameter int unsigned MAX_SIDE_LOG2 = 10
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [31:0]                         s_tdata,  // byte0, byte1, byte2, byte3
    input  logic [0:0]                          s_tuser,  // frame_start
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [55:0]                         m_tdata,  // element_index, texel_value, zero pad
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ttus_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ttus_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import ttus_pkg::*;

    localparam int unsigned SW = MAX_SIDE_LOG2;

    ttus_cfg_t cfg;

    logic          s_accept;
    logic          s1_advance;
    logic          out_ready;
    logic [SW-1:0] pos_x, pos_y;

    logic          s1_valid_reg, s1_valid_next;
    logic [SW-1:0] s1_x_reg, s1_y_reg;
    logic [31:0]   s1_bytes_reg;

    logic [INDEX_W-1:0] idx_comb;
    logic [TEXEL_W-1:0] val_comb;
    logic               last_comb;

    logic               m_valid_reg, m_valid_next;
    logic [INDEX_W-1:0] m_index_reg;
    logic [TEXEL_W-1:0] m_texel_reg;
    logic               m_last_reg;

    ttus_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign out_ready  = !m_valid_reg || m_tready;
    assign s1_advance = s1_valid_reg && out_ready;
    assign s_tready   = !s1_valid_reg || out_ready;
    assign s_accept   = s_tvalid && s_tready;

    ttus_pos #(
        .MAX_SIDE_LOG2 (MAX_SIDE_LOG2)
    ) u_pos (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .advance     (s_accept),
        .frame_start (s_tuser[0]),
        .pos_x       (pos_x),
        .pos_y       (pos_y)
    );

    ttus_pack #(
        .MAX_SIDE_LOG2 (MAX_SIDE_LOG2)
    ) u_pack (
        .cfg           (cfg),
        .pos_x         (s1_x_reg),
        .pos_y         (s1_y_reg),
        .src_bytes     (s1_bytes_reg),
        .element_index (idx_comb),
        .texel_value   (val_comb),
        .frame_last    (last_comb)
    );

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_advance) begin
            s1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (s1_advance) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_x_reg     <= pos_x;
            s1_y_reg     <= pos_y;
            s1_bytes_reg <= s_tdata;
        end
        if (s1_advance) begin
            m_index_reg <= idx_comb;
            m_texel_reg <= val_comb;
            m_last_reg  <= last_comb;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'h0, m_texel_reg, m_index_reg};
    assign m_tlast  = m_last_reg;

endmodule
